// ----- src/dad_pkg.sv -----
// ---------------------------------------------------------------------------
// dad_pkg: shared types, constants and tables for the date arithmetic block
// Day-number constants, month tables and step sizes for the year walker.
// ---------------------------------------------------------------------------
package dad_pkg;

  localparam int OFFSET_BITS = 21;
  localparam int SER_W       = 22;
  localparam int SUM_W       = 34;

  localparam logic [SER_W-1:0] SER_LO = 22'd306;
  localparam logic [SER_W-1:0] SER_HI = 22'd3652364;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LQ,
    S_LV,
    S_TS,
    S_FS,
    S_MON,
    S_OUT
  } dad_state_t;

  typedef struct packed {
    logic [SER_W-1:0] rem;
    logic [SER_W-1:0] step;
    logic [SER_W-1:0] acc;
    logic [SER_W-1:0] inc;
  } dad_op_t;

  typedef struct packed {
    logic             ge;
    logic [SER_W-1:0] rem;
    logic [SER_W-1:0] acc;
  } dad_res_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Days from March 1 to the first of month m.
  function automatic logic [8:0] month_off(input logic [3:0] m);
    logic [8:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      default: off = 9'd337;
    endcase
    return off;
  endfunction

  // Length of month index mp of a year that starts in March.
  function automatic logic [4:0] mar_len(input logic [3:0] mp);
    logic [4:0] len;
    case (mp)
      4'd1:    len = 5'd30;
      4'd3:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd11:   len = 5'd28;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [SER_W-1:0] yr_step(input logic [1:0] lvl);
    logic [SER_W-1:0] v;
    case (lvl)
      2'd0:    v = 22'd400;
      2'd1:    v = 22'd100;
      2'd2:    v = 22'd4;
      default: v = 22'd1;
    endcase
    return v;
  endfunction

  function automatic logic [SER_W-1:0] day_step(input logic [1:0] lvl);
    logic [SER_W-1:0] v;
    case (lvl)
      2'd0:    v = 22'd146097;
      2'd1:    v = 22'd36524;
      2'd2:    v = 22'd1461;
      default: v = 22'd365;
    endcase
    return v;
  endfunction

endpackage

// ----- src/dad_step.sv -----
// ---------------------------------------------------------------------------
// dad_step: shared compare, subtract and accumulate unit
// Compares the remainder with a step, subtracts it and advances an accumulator.
// ---------------------------------------------------------------------------
module dad_step import dad_pkg::*; (
  input  dad_op_t  op,
  output dad_res_t res
);

  assign res.ge  = (op.rem >= op.step);
  assign res.rem = op.rem - op.step;
  assign res.acc = op.acc + op.inc;

endmodule

// ----- src/date_add_days.sv -----
// ---------------------------------------------------------------------------
// date_add_days: Gregorian date plus day offset, or day difference of two dates
// Each date becomes a day number by walking 400, 100, 4 and 1 year steps, and a
// shifted day number is turned back by the same walk plus a walk over the months,
// all on one shared compare and subtract unit. A new item is taken the cycle after
// its result enters the output register, which holds it while out_ready is low.
// Synchronous reset clears the sequencer and out_valid only.
// ---------------------------------------------------------------------------
module date_add_days import dad_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic signed [20:0] in_day_offset,
  input  logic [13:0] in_other_year,
  input  logic [3:0]  in_other_month,
  input  logic [4:0]  in_other_day,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_result_year,
  output logic [3:0]  out_result_month,
  output logic [4:0]  out_result_day,
  output logic [21:0] out_day_count,
  output logic        out_bad_input,
  output logic        out_order_error
);

  dad_state_t state_r, state_nxt;
  logic        sel_r, sel_nxt;
  logic        kind_r;
  logic [13:0] ya_r, yb_r;
  logic [3:0]  ma_r, mb_r;
  logic [4:0]  da_r, db_r;
  logic [OFFSET_BITS-1:0] off_r;
  logic [6:0]  q_r, q_nxt;
  logic [1:0]  lvl_r, lvl_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [SER_W-1:0] rem_r, rem_nxt, acc_r, acc_nxt, a_r, a_nxt;
  logic [3:0]  mp_r, mp_nxt;
  logic [13:0] ry_r, ry_nxt;
  logic [3:0]  rm_r, rm_nxt;
  logic [4:0]  rd_r, rd_nxt;
  logic [21:0] rc_r, rc_nxt;
  logic        rb_r, rb_nxt, ro_r, ro_nxt;
  logic        ov_r, ov_nxt;
  logic [13:0] oy_r;
  logic [3:0]  om_r;
  logic [4:0]  od_r;
  logic [21:0] oc_r;
  logic        ob_r, oo_r;

  logic [13:0] ys;
  logic [3:0]  ms;
  logic [4:0]  ds;
  logic [26:0] qprod;
  logic [13:0] c100;
  logic        div100, leap, date_ok, lim;
  logic [13:0] yy;
  logic [3:0]  mm;
  logic signed [SUM_W-1:0] ssum;
  dad_op_t     op;
  dad_res_t    res;
  logic        accept, load_out;

  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == S_OUT) && (!ov_r || out_ready);

  assign ys = sel_r ? yb_r : ya_r;
  assign ms = sel_r ? mb_r : ma_r;
  assign ds = sel_r ? db_r : da_r;

  // q = floor(y / 100) by reciprocal multiply, exact for years up to 12799.
  assign qprod  = {13'd0, ys} * 27'd5243;
  assign c100   = {7'd0, q_r} * 14'd100;
  assign div100 = (c100 == ys);
  assign leap   = ((ys[1:0] == 2'd0) && !div100) || (div100 && (q_r[1:0] == 2'd0));
  assign date_ok = (ys >= 14'd1) && (ys <= 14'd9999) && (ms >= 4'd1) && (ms <= 4'd12) &&
                   (ds >= 5'd1) && (ds <= month_len(ms, leap));
  assign yy = ys - {13'd0, (ms <= 4'd2)};

  assign lim = ((lvl_r == 2'd1) || (lvl_r == 2'd3)) && (cnt_r == 2'd3);
  assign mm  = (mp_r < 4'd10) ? mp_r + 4'd3 : mp_r - 4'd9;

  assign ssum = $signed({{(SUM_W-SER_W){1'b0}}, acc_r}) +
                $signed({{(SUM_W-OFFSET_BITS){off_r[OFFSET_BITS-1]}},
                         off_r[OFFSET_BITS-1:0]});

  always_comb begin
    op.rem = rem_r;
    case (state_r)
      S_TS: begin
        op.step = yr_step(lvl_r);
        op.acc  = acc_r;
        op.inc  = day_step(lvl_r);
      end
      S_MON: begin
        op.step = {17'd0, mar_len(mp_r)};
        op.acc  = {18'd0, mp_r};
        op.inc  = 22'd1;
      end
      default: begin
        op.step = day_step(lvl_r);
        op.acc  = acc_r;
        op.inc  = yr_step(lvl_r);
      end
    endcase
  end

  dad_step u_step (
    .op  (op),
    .res (res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_LQ;
      S_LQ:   state_nxt = S_LV;
      S_LV:   state_nxt = date_ok ? S_TS : S_OUT;
      S_TS: begin
        if (!res.ge && (lvl_r == 2'd3)) begin
          if (sel_r || !kind_r) state_nxt = sel_r ? S_OUT : S_FS;
          else state_nxt = S_LQ;
        end
      end
      S_FS:   if (!(res.ge && !lim) && (lvl_r == 2'd3)) state_nxt = S_MON;
      S_MON:  if (!(res.ge && (mp_r < 4'd11))) state_nxt = S_OUT;
      S_OUT:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath.
  always_comb begin
    sel_nxt = sel_r;
    q_nxt   = q_r;
    lvl_nxt = lvl_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    acc_nxt = acc_r;
    a_nxt   = a_r;
    mp_nxt  = mp_r;
    ry_nxt  = ry_r;
    rm_nxt  = rm_r;
    rd_nxt  = rd_r;
    rc_nxt  = rc_r;
    rb_nxt  = rb_r;
    ro_nxt  = ro_r;
    case (state_r)
      S_IDLE: begin
        sel_nxt = 1'b0;
        ry_nxt = '0; rm_nxt = '0; rd_nxt = '0; rc_nxt = '0; rb_nxt = 1'b0; ro_nxt = 1'b0;
      end
      S_LQ: q_nxt = qprod[25:19];
      S_LV: begin
        if (!date_ok) begin
          rb_nxt = 1'b1;
        end else begin
          rem_nxt = {8'd0, yy};
          acc_nxt = {13'd0, month_off(ms)} + {17'd0, ds} - 22'd1;
          lvl_nxt = 2'd0;
        end
      end
      S_TS: begin
        if (res.ge) begin
          rem_nxt = res.rem;
          acc_nxt = res.acc;
        end else if (lvl_r != 2'd3) begin
          lvl_nxt = lvl_r + 2'd1;
        end else if (sel_r) begin
          if (acc_r > a_r) ro_nxt = 1'b1;
          else rc_nxt = a_r - acc_r;
        end else if (kind_r) begin
          a_nxt   = acc_r;
          sel_nxt = 1'b1;
        end else begin
          // Saturate the shifted day number to the supported years.
          if (ssum < $signed({{(SUM_W-SER_W){1'b0}}, SER_LO})) begin
            rem_nxt = SER_LO;
            ro_nxt  = 1'b1;
          end else if (ssum > $signed({{(SUM_W-SER_W){1'b0}}, SER_HI})) begin
            rem_nxt = SER_HI;
            ro_nxt  = 1'b1;
          end else begin
            rem_nxt = ssum[SER_W-1:0];
          end
          acc_nxt = '0;
          lvl_nxt = 2'd0;
          cnt_nxt = 2'd0;
        end
      end
      S_FS: begin
        if (res.ge && !lim) begin
          rem_nxt = res.rem;
          acc_nxt = res.acc;
          if (lvl_r[0]) cnt_nxt = cnt_r + 2'd1;
        end else if (lvl_r != 2'd3) begin
          lvl_nxt = lvl_r + 2'd1;
          cnt_nxt = 2'd0;
        end else begin
          mp_nxt = 4'd0;
        end
      end
      S_MON: begin
        if (res.ge && (mp_r < 4'd11)) begin
          rem_nxt = res.rem;
          mp_nxt  = res.acc[3:0];
        end else begin
          rd_nxt = rem_r[4:0] + 5'd1;
          rm_nxt = mm;
          ry_nxt = acc_r[13:0] + {13'd0, (mp_r >= 4'd10)};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (load_out) ov_nxt = 1'b1;
    else if (out_ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    q_r   <= q_nxt;
    lvl_r <= lvl_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    mp_r  <= mp_nxt;
    ry_r  <= ry_nxt;
    rm_r  <= rm_nxt;
    rd_r  <= rd_nxt;
    rc_r  <= rc_nxt;
    rb_r  <= rb_nxt;
    ro_r  <= ro_nxt;
    if (accept) begin
      kind_r <= in_kind;
      ya_r   <= in_year;
      ma_r   <= in_month;
      da_r   <= in_day;
      off_r  <= in_day_offset[OFFSET_BITS-1:0];
      yb_r   <= in_other_year;
      mb_r   <= in_other_month;
      db_r   <= in_other_day;
    end
    if (load_out) begin
      oy_r <= ry_r;
      om_r <= rm_r;
      od_r <= rd_r;
      oc_r <= rc_r;
      ob_r <= rb_r;
      oo_r <= ro_r;
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = ov_r;
  assign out_result_year  = oy_r;
  assign out_result_month = om_r;
  assign out_result_day   = od_r;
  assign out_day_count    = oc_r;
  assign out_bad_input    = ob_r;
  assign out_order_error  = oo_r;

endmodule

// ----- src/dad_checker.sv -----
// ---------------------------------------------------------------------------
// dad_checker: port-level assertions for the date arithmetic block
// Watches the handshakes and result consistency at the top-level ports.
// ---------------------------------------------------------------------------
module dad_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] out_result_year,
  input logic [21:0] out_day_count,
  input logic        out_bad_input,
  input logic        out_order_error
);

  // One item at a time: after a transfer in, the input side closes.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_day_count))
    else $error("stalled result changed");

  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_input |->
      out_day_count == 22'd0 && out_result_year == 14'd0 && !out_order_error)
    else $error("bad input result carries other fields");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_year != 14'd0) |-> out_day_count == 22'd0)
    else $error("date and day count both set");

endmodule

bind date_add_days dad_checker u_dad_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_year (out_result_year),
  .out_day_count   (out_day_count),
  .out_bad_input   (out_bad_input),
  .out_order_error (out_order_error)
);

// ----- test/date_add_days_tb.sv -----
// ---------------------------------------------------------------------------
// date_add_days_tb: self-checking bench for the Gregorian date arithmetic block
// Drives directed and random date items through the valid/ready channels,
// predicts each result with a day-number calendar model and compares the
// results in order, with random idling on both sides.
// ---------------------------------------------------------------------------
module date_add_days_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [21:0] count;
    logic        bad;
    logic        oerr;
  } date_result_t;

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint days_in_month(longint y, longint m);
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic bit real_date(longint y, longint m, longint d);
    if (y < 1 || y > 9999 || m < 1 || m > 12) return 0;
    return d >= 1 && d <= days_in_month(y, m);
  endfunction

  // Day number counted from March 1 of year zero.
  function automatic longint day_number(longint y, longint m, longint d);
    longint yy, mp;
    yy = y - ((m <= 2) ? 1 : 0);
    mp = (m + 9) % 12;
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + d - 1;
  endfunction

  class calendar_scoreboard;
    date_result_t pending[$];
    int errors;
    int shown;

    function void note_item(bit kind, logic [13:0] y1, logic [3:0] m1, logic [4:0] d1,
                            logic signed [20:0] off, logic [13:0] y2, logic [3:0] m2,
                            logic [4:0] d2);
      date_result_t r;
      longint s, era, doe, yoe, doy, mp, mm;
      r = '{default: '0};
      if (!kind) begin
        if (!real_date(y1, m1, d1)) r.bad = 1'b1;
        else begin
          s = day_number(y1, m1, d1) + longint'(off);
          if (s < day_number(1, 1, 1)) begin s = day_number(1, 1, 1); r.oerr = 1'b1; end
          if (s > day_number(9999, 12, 31)) begin
            s = day_number(9999, 12, 31);
            r.oerr = 1'b1;
          end
          era = s / 146097;
          doe = s - era * 146097;
          yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
          doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
          mp = (5 * doy + 2) / 153;
          mm = (mp < 10) ? mp + 3 : mp - 9;
          r.day = 5'(doy - (153 * mp + 2) / 5 + 1);
          r.month = 4'(mm);
          r.year = 14'(yoe + era * 400 + ((mm <= 2) ? 1 : 0));
        end
      end else begin
        if (!real_date(y1, m1, d1) || !real_date(y2, m2, d2)) r.bad = 1'b1;
        else if (day_number(y2, m2, d2) > day_number(y1, m1, d1)) r.oerr = 1'b1;
        else r.count = 22'(day_number(y1, m1, d1) - day_number(y2, m2, d2));
      end
      pending.push_back(r);
    endfunction

    function void check_result(date_result_t got);
      date_result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result transfer at %0t", $realtime);
        end
        return;
      end
      exp_r = pending.pop_front();
      if (got.year !== exp_r.year || got.month !== exp_r.month || got.day !== exp_r.day ||
          got.count !== exp_r.count || got.bad !== exp_r.bad || got.oerr !== exp_r.oerr) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: exp %0d-%0d-%0d cnt %0d bad %0b oerr %0b", exp_r.year,
                   exp_r.month, exp_r.day, exp_r.count, exp_r.bad, exp_r.oerr);
          $display("          got %0d-%0d-%0d cnt %0d bad %0b oerr %0b", got.year,
                   got.month, got.day, got.count, got.bad, got.oerr);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready, in_kind = 0;
  logic [13:0] in_year = 0, in_other_year = 0;
  logic [3:0] in_month = 0, in_other_month = 0;
  logic [4:0] in_day = 0, in_other_day = 0;
  logic signed [20:0] in_day_offset = 0;
  logic out_valid, out_ready = 0;
  logic [13:0] out_result_year;
  logic [3:0] out_result_month;
  logic [4:0] out_result_day;
  logic [21:0] out_day_count;
  logic out_bad_input, out_order_error;

  int send_idle_pct = 32, recv_idle_pct = 62;
  longint cycles = 0;
  calendar_scoreboard sb = new();

  always #10 clk = ~clk;

  date_add_days DUT (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: sample at the rising edge, change ready at the falling edge.
  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_result_year, out_result_month, out_result_day, out_day_count,
                        out_bad_input, out_order_error});

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic send_date(bit kind, int y1, int m1, int d1, int off, int y2, int m2, int d2);
    // Valid was dropped at the previous falling edge, so wait for a later falling edge to start.
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1;
    in_kind <= kind;
    in_year <= 14'(y1); in_month <= 4'(m1); in_day <= 5'(d1);
    in_day_offset <= 21'(off);
    in_other_year <= 14'(y2); in_other_month <= 4'(m2); in_other_day <= 5'(d2);
    do @(posedge clk); while (!in_ready);
    sb.note_item(kind, in_year, in_month, in_day, in_day_offset, in_other_year,
                 in_other_month, in_other_day);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic send_random();
    int y, m, y2, m2, off;
    y = ($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(9999, 1);
    m = ($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(12, 1);
    y2 = ($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(9999, 1);
    m2 = ($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(12, 1);
    case ($urandom_range(3))
      0: off = $urandom_range(2097151) - 1048576;
      1: off = $urandom_range(800) - 400;
      default: off = $urandom_range(80000) - 40000;
    endcase
    if ($urandom_range(2) == 0)
      y2 = y - $urandom_range(3) > 0 ? y - $urandom_range(3) : 1;
    send_date($urandom_range(1), y, m, ($urandom_range(15) == 0) ? $urandom_range(31)
              : $urandom_range(days_in_month(y, m < 1 || m > 12 ? 1 : m), 1), off,
              y2, m2, ($urandom_range(15) == 0) ? $urandom_range(31)
              : $urandom_range(days_in_month(y2, m2 < 1 || m2 > 12 ? 1 : m2), 1));
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // Directed: extremes, leap rules, invalid dates, saturation, reversed order.
    send_date(0, 1, 1, 1, 0, 1, 1, 1);
    send_date(0, 1, 1, 1, -1, 1, 1, 1);
    send_date(0, 9999, 12, 31, 1, 1, 1, 1);
    send_date(0, 9999, 12, 31, -1048576, 1, 1, 1);
    send_date(0, 1, 1, 1, 1048575, 1, 1, 1);
    send_date(0, 2000, 2, 28, 1, 1, 1, 1);
    send_date(0, 1900, 2, 28, 1, 1, 1, 1);
    send_date(0, 2024, 3, 1, -1, 1, 1, 1);
    send_date(0, 2023, 12, 31, 1, 1, 1, 1);
    send_date(0, 2023, 4, 31, 5, 1, 1, 1);
    send_date(0, 1900, 2, 29, 0, 1, 1, 1);
    send_date(0, 0, 1, 1, 0, 1, 1, 1);
    send_date(0, 16383, 15, 31, 0, 1, 1, 1);
    send_date(0, 2020, 0, 0, 0, 1, 1, 1);
    send_date(1, 9999, 12, 31, 0, 1, 1, 1);
    send_date(1, 1, 1, 1, 0, 9999, 12, 31);
    send_date(1, 2000, 3, 1, 0, 2000, 2, 29);
    send_date(1, 2000, 3, 1, 0, 2000, 3, 1);
    send_date(1, 2000, 3, 1, 0, 2000, 2, 30);
    send_date(1, 16383, 15, 31, -1, 16383, 15, 31);
    drain();
    // Pause with nothing pending before the random part.
    repeat (150) @(posedge clk);
    for (int i = 0; i < 800; i++) begin
      if (i == 300) begin send_idle_pct = 62; recv_idle_pct = 32; end
      if (i == 550) begin send_idle_pct = 0; recv_idle_pct = 0; end
      send_random();
    end
    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
